[rtl/core/dblc_pkg.sv]
// Shared types and constants for the debounced button LED chaser.
// No dependencies; imported by the core, its port checker and the testbench.
package dblc_pkg;

  // Fixed field widths
  localparam int unsigned ThreshW  = 4;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned PatternW = 8;
  localparam int unsigned SpeedW   = 2;

  // Speed table depth (fixed by the register map)
  localparam int unsigned SPEED_COUNT = 4;

  // Stream and configuration port widths
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = PeriodW;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CFG_STABLE_THRESHOLD = 3'd0,
    CFG_PERIOD_SLOWEST   = 3'd1,
    CFG_PERIOD_SLOW      = 3'd2,
    CFG_PERIOD_FAST      = 3'd3,
    CFG_PERIOD_FASTEST   = 3'd4
  } cfg_idx_e;

  // Register reset values
  localparam logic [ThreshW-1:0] ThreshReset = 4'd5;
  localparam logic [PeriodW-1:0] PeriodSlowestReset = 16'd600;
  localparam logic [PeriodW-1:0] PeriodSlowReset    = 16'd300;
  localparam logic [PeriodW-1:0] PeriodFastReset    = 16'd150;
  localparam logic [PeriodW-1:0] PeriodFastestReset = 16'd75;

  // One result transaction, packed highest field first
  typedef struct packed {
    logic [3:0]          pad;
    logic [SpeedW-1:0]   speed_selected;
    logic                clicked;
    logic                led_stepped;
    logic [PatternW-1:0] led_pattern;
  } result_t;

endpackage

[rtl/core/debounced_button_led_chaser.sv]
// Top level of the debounced button LED chaser: debounce, speed select,
// LED stepping and a two-entry output buffer. Depends on dblc_pkg.
//
// Each input transaction is one poll (button level, millisecond time). The
// block takes one poll per clock unless stalled and returns exactly one
// result for it in the output register, or in the skid register behind it
// while that one is full, at the clock edge that accepts the poll, so the
// result can be taken in the next cycle at the earliest. The whole
// update is combinational logic from the poll and the state registers
// into the output register, the longest path running from the debounce
// through the speed select and the period mux into the 32-bit elapsed-time
// compare. The input stalls only when both registers hold results.
// Configuration writes land at once and are meant for idle periods.
module debounced_button_led_chaser #(
  parameter int unsigned LED_COUNT = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [dblc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [dblc_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Poll stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: [0] button_level, [32:1] now_ms, [39:33] zero
  input  logic [dblc_pkg::InDataW-1:0]  s_axis_tdata,
  // Result stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: [7:0] led_pattern, [8] led_stepped, [9] clicked,
  //        [11:10] speed_selected, [15:12] zero
  output logic [dblc_pkg::OutDataW-1:0] m_axis_tdata
);
  import dblc_pkg::*;

  localparam int unsigned PosW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  // Configuration registers
  logic [ThreshW-1:0] thresh_q;
  logic [PeriodW-1:0] period_q [SPEED_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= ThreshReset;
      period_q[0] <= PeriodSlowestReset;
      period_q[1] <= PeriodSlowReset;
      period_q[2] <= PeriodFastReset;
      period_q[3] <= PeriodFastestReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_STABLE_THRESHOLD: thresh_q    <= cfg_wdata_i[ThreshW-1:0];
        CFG_PERIOD_SLOWEST:   period_q[0] <= cfg_wdata_i;
        CFG_PERIOD_SLOW:      period_q[1] <= cfg_wdata_i;
        CFG_PERIOD_FAST:      period_q[2] <= cfg_wdata_i;
        CFG_PERIOD_FASTEST:   period_q[3] <= cfg_wdata_i;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // Handshake bookkeeping
  logic in_acc, out_take;
  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  result_t out_q, out_d, skid_q, skid_d;

  assign s_axis_tready = !skid_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_take      = out_valid_q && m_axis_tready;

  // Poll fields
  logic             level;
  logic [TimeW-1:0] now_ms;
  assign level  = s_axis_tdata[0];
  assign now_ms = s_axis_tdata[TimeW:1];

  // State registers
  logic               last_sample_q, last_sample_d;
  logic               stable_q, stable_d;
  logic [ThreshW-1:0] streak_q, streak_d;
  logic [SpeedW-1:0]  speed_q, speed_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [TimeW-1:0]   last_time_q, last_time_d;
  logic [PatternW-1:0] drive_q, drive_d;

  // Per-poll update
  logic              confirmed, click, step;
  logic [TimeW-1:0]  elapsed;
  logic [PosW:0]     pos_inc;
  logic [SpeedW:0]   speed_inc;
  result_t           res;

  always_comb begin
    // debounce streak
    last_sample_d = last_sample_q;
    streak_d      = streak_q;
    if (level == last_sample_q) begin
      if (streak_q < thresh_q) streak_d = streak_q + 4'd1;
    end else begin
      last_sample_d = level;
      streak_d      = 4'd1;
    end
    confirmed = (streak_d >= thresh_q);
    stable_d  = stable_q;
    click     = 1'b0;
    if (confirmed && (level != stable_q)) begin
      stable_d = level;
      click    = level;
    end

    // speed select, wrapping
    speed_inc = {1'b0, speed_q} + 3'd1;
    speed_d   = speed_q;
    if (click) begin
      speed_d = (speed_inc >= 3'(SPEED_COUNT)) ? '0 : speed_inc[SpeedW-1:0];
    end

    // LED step when elapsed time reaches the selected period
    elapsed     = now_ms - last_time_q;
    step        = (elapsed >= {{(TimeW-PeriodW){1'b0}}, period_q[speed_d]});
    pos_inc     = {1'b0, pos_q} + {{PosW{1'b0}}, 1'b1};
    last_time_d = last_time_q;
    drive_d     = drive_q;
    pos_d       = pos_q;
    if (step) begin
      last_time_d = now_ms;
      drive_d     = PatternW'(1) << pos_q;  // zero past the eighth LED
      pos_d       = (pos_inc >= (PosW+1)'(LED_COUNT)) ? '0 : pos_inc[PosW-1:0];
    end

    res                = '0;
    res.led_pattern    = drive_d;
    res.led_stepped    = step;
    res.clicked        = click;
    res.speed_selected = speed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sample_q <= 1'b0;
      stable_q      <= 1'b0;
      streak_q      <= 4'd1;
      speed_q       <= '0;
      pos_q         <= '0;
      last_time_q   <= '0;
      drive_q       <= '0;
    end else if (in_acc) begin
      last_sample_q <= last_sample_d;
      stable_q      <= stable_d;
      streak_q      <= streak_d;
      speed_q       <= speed_d;
      pos_q         <= pos_d;
      last_time_q   <= last_time_d;
      drive_q       <= drive_d;
    end
  end

  // Output register with skid stage
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_take) begin
      out_valid_d  = skid_valid_q || in_acc;
      out_d        = skid_valid_q ? skid_q : res;
      skid_valid_d = 1'b0;
    end else if (in_acc) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

[rtl/core/dblc_checker.sv]
// Port-level checks for debounced_button_led_chaser, bound to the top level.
// Depends on dblc_pkg for the port widths.
module dblc_checker #(
  parameter int unsigned LED_COUNT = 8
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [dblc_pkg::OutDataW-1:0] m_axis_tdata
);
  import dblc_pkg::*;

  // LED drive is never more than one lit LED
  a_onehot_leds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[PatternW-1:0]))
    else $error("led_pattern has more than one LED lit");

  // A step always lights an LED when every position fits the drive bits
  a_step_lights: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[PatternW] && (LED_COUNT <= PatternW))
      |-> (m_axis_tdata[PatternW-1:0] != '0))
    else $error("LED step with dark pattern");

  // Input stalls only while a result is waiting
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // Pending result holds until taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed or dropped while stalled");

endmodule

bind debounced_button_led_chaser dblc_checker #(
  .LED_COUNT(LED_COUNT)
) u_dblc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/testbench.sv]
// Self-checking testbench for debounced_button_led_chaser: poll stream in, result stream out.
// Predicts every result from its own copy of the debounce, speed and LED state.
// Depends on dblc_pkg and the debounced_button_led_chaser RTL.
`timescale 1ns / 100ps

module testbench;
  import dblc_pkg::*;

  localparam int unsigned LedCount  = 8;
  localparam int unsigned HoldStart = 400;  // polls accepted before the long receiver hold-off
  localparam int unsigned HoldLen   = 300;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // tdata: [0] button_level, [32:1] now_ms, [39:33] zero
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // tdata: [7:0] led_pattern, [8] led_stepped, [9] clicked, [11:10] speed_selected, [15:12] zero
  logic [OutDataW-1:0] m_axis_tdata;

  debounced_button_led_chaser #(
    .LED_COUNT(LedCount)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Register copies
  logic [ThreshW-1:0] cfg_threshold = ThreshReset;
  logic [PeriodW-1:0] cfg_period [SPEED_COUNT] =
    '{PeriodSlowestReset, PeriodSlowReset, PeriodFastReset, PeriodFastestReset};

  // Debounce, speed and LED state
  logic               last_sample   = 1'b0;
  logic               settled_level = 1'b0;
  logic [ThreshW-1:0] streak        = 4'd1;
  logic [SpeedW-1:0]  speed_idx     = '0;
  int unsigned        led_pos       = 0;
  logic [TimeW-1:0]   prev_step_ms  = '0;
  logic [PatternW-1:0] led_drive    = '0;

  logic [InDataW-1:0] pending_polls [$];
  result_t            expected_results [$];
  int unsigned        polls_queued   = 0;
  int unsigned        polls_accepted = 0;
  int unsigned        mismatches     = 0;
  logic [TimeW-1:0]   poll_time      = '0;

  int unsigned send_wait = 0, send_calm = 0;
  int unsigned recv_wait = 0, recv_calm = 0;
  int unsigned hold_left = 0, hold_polls = 0;
  logic        hold_done = 1'b0;

  // Advance the chaser state by one poll and return its result
  function automatic result_t poll_update(input logic level, input logic [TimeW-1:0] now);
    result_t res;
    logic    click;
    click = 1'b0;
    if (level == last_sample) begin
      if (streak < cfg_threshold) streak = streak + 4'd1;
    end else begin
      last_sample = level;
      streak      = 4'd1;
    end
    // Confirmed level change; only 0 -> 1 counts as a click
    if (streak >= cfg_threshold && level != settled_level) begin
      click         = !settled_level && level;
      settled_level = level;
    end
    if (click) speed_idx = (speed_idx == SpeedW'(SPEED_COUNT - 1)) ? '0 : speed_idx + 1'b1;
    res = '0;
    if (TimeW'(now - prev_step_ms) >= TimeW'(cfg_period[speed_idx])) begin
      prev_step_ms = now;
      led_drive = (led_pos < PatternW) ? PatternW'(1 << led_pos) : '0;
      led_pos   = (led_pos + 1 >= LedCount) ? 0 : led_pos + 1;
      res.led_stepped = 1'b1;
    end
    res.led_pattern    = led_drive;
    res.clicked        = click;
    res.speed_selected = speed_idx;
    return res;
  endfunction

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result transaction %0h", got);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (got.led_pattern !== want.led_pattern) begin
        $error("led_pattern: expected %0h, got %0h", want.led_pattern, got.led_pattern);
        mismatches++;
      end
      if (got.led_stepped !== want.led_stepped) begin
        $error("led_stepped: expected %0b, got %0b", want.led_stepped, got.led_stepped);
        mismatches++;
      end
      if (got.clicked !== want.clicked) begin
        $error("clicked: expected %0b, got %0b", want.clicked, got.clicked);
        mismatches++;
      end
      if (got.speed_selected !== want.speed_selected) begin
        $error("speed_selected: expected %0d, got %0d", want.speed_selected, got.speed_selected);
        mismatches++;
      end
    end
  endtask

  // Poll driver: random gaps between transactions, with calm stretches
  always @(posedge clk_i) begin : poll_driver
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(poll_update(s_axis_tdata[0], s_axis_tdata[TimeW:1]));
        polls_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_wait != 0) begin
          s_axis_tvalid <= 1'b0;
          send_wait     <= send_wait - 1;
        end else if (pending_polls.size() != 0) begin
          s_axis_tdata  <= pending_polls.pop_front();
          s_axis_tvalid <= 1'b1;
          if (send_calm != 0) begin
            send_wait <= 0;
            send_calm <= send_calm - 1;
          end else begin
            send_wait <= $urandom_range(0, 7);
            if ($urandom_range(0, 15) == 0) send_calm <= $urandom_range(8, 40);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off so the block fills and stalls its input
  always @(posedge clk_i) begin : receiver_hold
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) hold_polls <= hold_polls + 1;
      if (!hold_done && hold_polls >= HoldStart) begin
        hold_left <= HoldLen;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Result monitor: checks each transaction, then stalls a random count
  always @(posedge clk_i) begin : result_monitor
    int unsigned next_wait;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      next_wait = recv_wait;
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(result_t'(m_axis_tdata));
        if (recv_calm != 0) begin
          next_wait = 0;
          recv_calm <= recv_calm - 1;
        end else begin
          next_wait = $urandom_range(0, 7);
          if ($urandom_range(0, 15) == 0) recv_calm <= $urandom_range(8, 40);
        end
      end else if (next_wait != 0) begin
        next_wait--;
      end
      recv_wait     <= next_wait;
      m_axis_tready <= (next_wait == 0) && (hold_left == 0);
    end
  end

  task automatic queue_poll(input logic level, input logic [TimeW-1:0] now);
    pending_polls.push_back({7'b0, now, level});
    polls_queued++;
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == CFG_STABLE_THRESHOLD) cfg_threshold = value[ThreshW-1:0];
    else if (addr >= CFG_PERIOD_SLOWEST && addr <= CFG_PERIOD_FASTEST)
      cfg_period[addr - CFG_PERIOD_SLOWEST] = value;
  endtask

  // All registers, junk in the threshold's upper bits, plus a write to an unmapped index
  task automatic apply_settings(input logic [ThreshW-1:0] thr, input logic [PeriodW-1:0] p0,
                                input logic [PeriodW-1:0] p1, input logic [PeriodW-1:0] p2,
                                input logic [PeriodW-1:0] p3);
    write_reg(CFG_STABLE_THRESHOLD, {12'($urandom()), thr});
    write_reg(CFG_PERIOD_SLOWEST, p0);
    write_reg(CFG_PERIOD_SLOW, p1);
    write_reg(CFG_PERIOD_FAST, p2);
    write_reg(CFG_PERIOD_FASTEST, p3);
    write_reg(CfgAddrW'(CFG_PERIOD_FASTEST + 1 + $urandom_range(0, 2)), 16'($urandom()));
  endtask

  task automatic wait_drained();
    while (polls_accepted != polls_queued || expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [PeriodW-1:0] pick_period();
    if ($urandom_range(0, 4) == 0) return PeriodW'($urandom());
    return PeriodW'($urandom_range(0, 1000));
  endfunction

  // Mostly debounced runs of one level, some bounces and random noise
  task automatic queue_random_polls(input int unsigned count);
    int unsigned queued, run_len, k;
    logic        level;
    queued = 0;
    level  = $urandom_range(0, 1);
    while (queued < count) begin
      if ($urandom_range(0, 9) == 0) level = $urandom_range(0, 1);
      else level = ~level;
      if ($urandom_range(0, 4) == 0) run_len = $urandom_range(1, cfg_threshold + 1);
      else run_len = cfg_threshold + $urandom_range(0, 4);
      if (run_len == 0) run_len = 1;
      for (k = 0; k < run_len && queued < count; k++) begin
        case ($urandom_range(0, 9))
          0:       poll_time = $urandom();
          1, 2:    poll_time = poll_time + $urandom_range(0, 70000);
          default: poll_time = poll_time + $urandom_range(0, 150);
        endcase
        queue_poll(level, poll_time);
        queued++;
      end
    end
  endtask

  // Main sequence
  initial begin : main_sequence
    int unsigned k;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: first poll measured from time 0, a click, wrap of the time base
    queue_poll(1'b0, 32'd0);
    queue_poll(1'b0, 32'd599);
    queue_poll(1'b0, 32'd600);
    for (k = 0; k < 5; k++) queue_poll(1'b1, 32'd601 + k);
    queue_poll(1'b1, 32'hFFFF_FFF0);
    queue_poll(1'b0, 32'h0000_0100);
    queue_poll(1'b0, 32'h0000_0120);
    wait_drained();

    // Zero threshold and zero periods: every sample confirmed, a step on every poll
    apply_settings(4'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    for (k = 0; k < 8; k++) queue_poll(k[0] ? 1'b0 : 1'b1, 32'hFFFF_FFFF);
    wait_drained();

    // Random phases, extremes first
    poll_time = $urandom();
    apply_settings(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random_polls(255);
    wait_drained();
    apply_settings(4'd1, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_random_polls(255);
    wait_drained();
    apply_settings(4'd0, pick_period(), pick_period(), pick_period(), pick_period());
    queue_random_polls(255);
    wait_drained();
    for (k = 0; k < 3; k++) begin
      apply_settings(ThreshW'($urandom_range(1, 15)), pick_period(), pick_period(),
                     pick_period(), pick_period());
      queue_random_polls(255);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin : run_limit
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
